FILE: src/dnsttl_pkg.sv
// Shared types and constants for the DNS answer minimum-TTL scanner.
// No dependencies; imported by dnsttl_parser and the top level.
package dnsttl_pkg;

    localparam int TTL_W = 31;

    // Parse phases.
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_QNAME  = 3'd1;
    localparam logic [2:0] PH_QFIXED = 3'd2;
    localparam logic [2:0] PH_ANAME  = 3'd3;
    localparam logic [2:0] PH_AFIXED = 3'd4;
    localparam logic [2:0] PH_RDATA  = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    // Last index of each fixed-length field group.
    localparam logic [3:0] HEADER_LAST = 4'd11;
    localparam logic [3:0] QFIXED_LAST = 4'd3;
    localparam logic [3:0] AFIXED_LAST = 4'd9;

    // Header byte offsets of the counts.
    localparam logic [3:0] HDR_QD_HI = 4'd4;
    localparam logic [3:0] HDR_QD_LO = 4'd5;
    localparam logic [3:0] HDR_AN_HI = 4'd6;
    localparam logic [3:0] HDR_AN_LO = 4'd7;

    // Answer fixed-part offsets.
    localparam logic [3:0] AF_TTL_FIRST = 4'd4;
    localparam logic [3:0] AF_TTL_LAST  = 4'd7;
    localparam logic [3:0] AF_RDLEN_HI  = 4'd8;
    localparam logic [3:0] AF_RDLEN_LO  = 4'd9;

    localparam logic [1:0] LABEL_PLAIN   = 2'b00;
    localparam logic [1:0] LABEL_POINTER = 2'b11;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } dnsttl_byte_t;

    typedef struct packed {
        logic             valid;
        logic [TTL_W-1:0] min_ttl;
    } dnsttl_result_t;

endpackage

FILE: src/dnsttl_parser.sv
// Byte-wise DNS message parser: state registers and their one-byte update.
// Depends on dnsttl_pkg; produces one result on the last byte of a message.
module dnsttl_parser
    import dnsttl_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  dnsttl_byte_t   in_byte,
    output dnsttl_result_t result
);

    logic [2:0]       phase_reg,    phase_next,    phase_step;
    logic [3:0]       header_reg,   header_next,   header_step;
    logic [15:0]      qleft_reg,    qleft_next,    qleft_step;
    logic [15:0]      aleft_reg,    aleft_next,    aleft_step;
    logic [5:0]       skip_reg,     skip_next,     skip_step;
    logic [3:0]       fixed_reg,    fixed_next,    fixed_step;
    logic [31:0]      ttl_reg,      ttl_next,      ttl_step;
    logic [15:0]      rdlen_reg,    rdlen_next,    rdlen_step;
    logic [TTL_W-1:0] best_reg,     best_next,     best_step;
    logic             have_reg,     have_next,     have_step;
    logic             bad_reg,      bad_next,      bad_step;

    logic [7:0]       b;
    logic [1:0]       label_type;
    logic [15:0]      aleft_dec;
    logic [15:0]      qleft_dec;
    logic [TTL_W-1:0] ttl_eff;

    assign b          = in_byte.data;
    assign label_type = b[7:6];
    assign aleft_dec  = aleft_reg - 16'd1;
    assign qleft_dec  = qleft_reg - 16'd1;
    // A TTL with its top bit set counts as zero.
    assign ttl_eff    = ttl_reg[31] ? '0 : ttl_reg[TTL_W-1:0];

    always_comb begin
        phase_step  = phase_reg;
        header_step = header_reg;
        qleft_step  = qleft_reg;
        aleft_step  = aleft_reg;
        skip_step   = skip_reg;
        fixed_step  = fixed_reg;
        ttl_step    = ttl_reg;
        rdlen_step  = rdlen_reg;
        best_step   = best_reg;
        have_step   = have_reg;
        bad_step    = bad_reg;

        if (in_byte.valid && !bad_reg) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (header_reg == HDR_QD_HI) begin
                        qleft_step = {b, 8'h00};
                    end else if (header_reg == HDR_QD_LO) begin
                        qleft_step = {qleft_reg[15:8], b};
                    end else if (header_reg == HDR_AN_HI) begin
                        aleft_step = {b, 8'h00};
                    end else if (header_reg == HDR_AN_LO) begin
                        aleft_step = {aleft_reg[15:8], b};
                    end
                    header_step = header_reg + 4'd1;
                    if (header_reg == HEADER_LAST) begin
                        if (qleft_reg != 16'd0) begin
                            phase_step = PH_QNAME;
                        end else begin
                            phase_step = (aleft_reg != 16'd0) ? PH_ANAME : PH_DONE;
                        end
                    end
                end
                PH_QNAME, PH_ANAME: begin
                    if (skip_reg != 6'd0) begin
                        skip_step = skip_reg - 6'd1;
                    end else if (b == 8'd0) begin
                        phase_step = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                        fixed_step = '0;
                    end else if (label_type == LABEL_POINTER) begin
                        // The pointer's second byte is skipped in the fixed phase.
                        phase_step = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                        fixed_step = '0;
                        skip_step  = 6'd1;
                    end else if (label_type != LABEL_PLAIN) begin
                        bad_step = 1'b1;
                    end else begin
                        skip_step = b[5:0];
                    end
                end
                PH_QFIXED: begin
                    if (skip_reg != 6'd0) begin
                        skip_step = skip_reg - 6'd1;
                    end else begin
                        fixed_step = fixed_reg + 4'd1;
                        if (fixed_reg == QFIXED_LAST) begin
                            qleft_step = qleft_dec;
                            if (qleft_dec != 16'd0) begin
                                phase_step = PH_QNAME;
                            end else begin
                                phase_step = (aleft_reg != 16'd0) ? PH_ANAME : PH_DONE;
                            end
                        end
                    end
                end
                PH_AFIXED: begin
                    if (skip_reg != 6'd0) begin
                        skip_step = skip_reg - 6'd1;
                    end else begin
                        if (fixed_reg >= AF_TTL_FIRST && fixed_reg <= AF_TTL_LAST) begin
                            ttl_step = {ttl_reg[23:0], b};
                        end else if (fixed_reg == AF_RDLEN_HI) begin
                            rdlen_step = {b, 8'h00};
                        end else if (fixed_reg == AF_RDLEN_LO) begin
                            rdlen_step = {rdlen_reg[15:8], b};
                        end
                        fixed_step = fixed_reg + 4'd1;
                        if (fixed_reg == AFIXED_LAST) begin
                            if (!have_reg || ttl_eff < best_reg) begin
                                best_step = ttl_eff;
                            end
                            have_step = 1'b1;
                            if ({rdlen_reg[15:8], b} == 16'd0) begin
                                aleft_step = aleft_dec;
                                phase_step = (aleft_dec != 16'd0) ? PH_ANAME : PH_DONE;
                            end else begin
                                phase_step = PH_RDATA;
                            end
                        end
                    end
                end
                PH_RDATA: begin
                    rdlen_step = rdlen_reg - 16'd1;
                    if (rdlen_reg == 16'd1) begin
                        aleft_step = aleft_dec;
                        phase_step = (aleft_dec != 16'd0) ? PH_ANAME : PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        result.valid   = in_byte.valid && in_byte.last;
        result.min_ttl = (!bad_step && phase_step == PH_DONE && have_step) ? best_step : '0;
    end

    // The last byte of a message returns every register to its reset value.
    always_comb begin
        if (in_byte.valid && in_byte.last) begin
            phase_next  = PH_HEADER;
            header_next = '0;
            qleft_next  = '0;
            aleft_next  = '0;
            skip_next   = '0;
            fixed_next  = '0;
            ttl_next    = '0;
            rdlen_next  = '0;
            best_next   = '0;
            have_next   = 1'b0;
            bad_next    = 1'b0;
        end else begin
            phase_next  = phase_step;
            header_next = header_step;
            qleft_next  = qleft_step;
            aleft_next  = aleft_step;
            skip_next   = skip_step;
            fixed_next  = fixed_step;
            ttl_next    = ttl_step;
            rdlen_next  = rdlen_step;
            best_next   = best_step;
            have_next   = have_step;
            bad_next    = bad_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            qleft_reg  <= '0;
            aleft_reg  <= '0;
            skip_reg   <= '0;
            fixed_reg  <= '0;
            ttl_reg    <= '0;
            rdlen_reg  <= '0;
            best_reg   <= '0;
            have_reg   <= 1'b0;
            bad_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            qleft_reg  <= qleft_next;
            aleft_reg  <= aleft_next;
            skip_reg   <= skip_next;
            fixed_reg  <= fixed_next;
            ttl_reg    <= ttl_next;
            rdlen_reg  <= rdlen_next;
            best_reg   <= best_next;
            have_reg   <= have_next;
            bad_reg    <= bad_next;
        end
    end

    a_header_range: assert property (@(posedge aclk) disable iff (!aresetn)
        header_reg <= HEADER_LAST + 4'd1)
        else $error("header index ran past the header");

    a_fixed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fixed_reg <= AFIXED_LAST + 4'd1)
        else $error("fixed index ran past the answer fixed part");

    a_rdata_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RDATA |-> rdlen_reg != 16'd0)
        else $error("RDATA phase entered with zero length");

    a_header_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        header_reg != HEADER_LAST + 4'd1 |-> phase_reg == PH_HEADER)
        else $error("left the header phase before twelve bytes");

endmodule

FILE: src/dns_answer_min_ttl_scanner_unit.sv
// Top level of the DNS answer minimum-TTL scanner: handshakes and result register.
// Depends on dnsttl_pkg and dnsttl_parser.
//
// Usage: a DNS message enters on the s_ channel one byte per word, in wire
// order, with s_last_byte set on its final byte. Each accepted word updates
// the parser's counters in the same cycle, so one byte is taken every cycle
// while s_ready is high. Only the word that carries s_last_byte yields a
// result: m_min_ttl holds the smallest answer TTL of the message, or zero
// when there is no answer, the message is truncated or short, or a reserved
// label type appears. The result is registered and appears on m_valid in the
// cycle after the last byte is accepted. The parser is ready for the next
// message's first byte in the cycle after. A single result register sits
// between the channels; while it holds a result that the receiver has not
// taken, input bytes are still accepted unless that result is stalled and a
// new one would be due, in which case s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) clears the parser to the start of a
// message and empties the result register.
module dns_answer_min_ttl_scanner_unit
    import dnsttl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_last_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [TTL_W-1:0] m_min_ttl
);

    dnsttl_byte_t     in_byte;
    dnsttl_result_t   result;
    logic             m_valid_reg, m_valid_next;
    logic [TTL_W-1:0] m_min_ttl_reg;
    logic             s_accept;

    // Stall only when a held result is still waiting and this byte ends a message.
    assign s_ready  = !m_valid_reg || m_ready || !s_last_byte;
    assign s_accept = s_valid && s_ready;

    assign in_byte.valid = s_accept;
    assign in_byte.data  = s_data_byte;
    assign in_byte.last  = s_last_byte;

    dnsttl_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (in_byte),
        .result  (result)
    );

    always_comb begin
        if (result.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_min_ttl_reg <= result.min_ttl;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_min_ttl = m_min_ttl_reg;

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_byte |=> m_valid)
        else $error("last byte accepted without a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !result.valid)
        else $error("result register overwritten while stalled");

    a_mid_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_byte && !m_valid |=> !m_valid)
        else $error("result produced by a byte that is not last");

endmodule

FILE: sim/dns_answer_min_ttl_scanner_unit_tb.sv
// Self-checking testbench for dns_answer_min_ttl_scanner_unit: builds DNS messages,
// streams them byte by byte and checks every minimum-TTL result against a local parser.
// Depends on dnsttl_pkg and the scanner RTL.
module dns_answer_min_ttl_scanner_unit_tb
    import dnsttl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int STALL_CYCLES = 400;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;
    } scan_word_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_data_byte = 8'h00;
    logic             s_last_byte = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [TTL_W-1:0] m_min_ttl;

    dns_answer_min_ttl_scanner_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_ttl   (m_min_ttl)
    );

    scan_word_t       word_queue[$];
    logic [TTL_W-1:0] ttl_due[$];
    logic [7:0]       msg[$];
    logic [31:0]      ttl_plan[$];
    int               poison_name = -1;
    int               name_no = 0;
    bit               poison_top = 1'b0;
    int               msgs_built = 0;
    int               msgs_clean = 0;
    int               bytes_sent = 0;
    int               results_seen = 0;
    int               errors = 0;
    int               cycles = 0;

    // Parser state mirrored from the block.
    logic [2:0]  phase = PH_HEADER;
    logic [3:0]  hdr_idx = '0;
    logic [15:0] qd_left = '0;
    logic [15:0] an_left = '0;
    logic [15:0] skip_cnt = '0;
    logic [3:0]  fix_idx = '0;
    logic [31:0] ttl_acc = '0;
    logic [15:0] rd_left = '0;
    logic [31:0] best = '0;
    bit          seen_answer = 1'b0;
    bit          bad = 1'b0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL dns_answer_min_ttl_scanner_unit");
            $finish;
        end
    end

    task automatic clear_scan();
        phase = PH_HEADER;
        hdr_idx = '0;
        qd_left = '0;
        an_left = '0;
        skip_cnt = '0;
        fix_idx = '0;
        ttl_acc = '0;
        rd_left = '0;
        best = '0;
        seen_answer = 1'b0;
        bad = 1'b0;
    endtask

    function automatic logic [2:0] answer_phase();
        return (an_left == 16'd0) ? PH_DONE : PH_ANAME;
    endfunction

    task automatic answer_done();
        an_left--;
        phase = answer_phase();
    endtask

    task automatic name_step(input logic [7:0] b, input logic [2:0] fixed_phase);
        if (skip_cnt != 16'd0) begin
            skip_cnt--;
        end else if (b == 8'h00) begin
            phase = fixed_phase;
            fix_idx = '0;
        end else if (b[7:6] == LABEL_POINTER) begin
            // The pointer's second byte is swallowed by the fixed phase.
            phase = fixed_phase;
            fix_idx = '0;
            skip_cnt = 16'd1;
        end else if (b[7:6] != LABEL_PLAIN) begin
            bad = 1'b1;
        end else begin
            skip_cnt = {8'h00, b};
        end
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic is_last);
        logic [31:0] ttl;
        if (!bad) begin
            case (phase)
                PH_HEADER: begin
                    case (hdr_idx)
                        HDR_QD_HI: qd_left = {b, 8'h00};
                        HDR_QD_LO: qd_left[7:0] = b;
                        HDR_AN_HI: an_left = {b, 8'h00};
                        HDR_AN_LO: an_left[7:0] = b;
                        default: ;
                    endcase
                    if (hdr_idx == HEADER_LAST) begin
                        phase = (qd_left == 16'd0) ? answer_phase() : PH_QNAME;
                    end
                    hdr_idx++;
                end
                PH_QNAME: name_step(b, PH_QFIXED);
                PH_QFIXED: begin
                    if (skip_cnt != 16'd0) begin
                        skip_cnt--;
                    end else begin
                        if (fix_idx == QFIXED_LAST) begin
                            qd_left--;
                            phase = (qd_left == 16'd0) ? answer_phase() : PH_QNAME;
                        end
                        fix_idx++;
                    end
                end
                PH_ANAME: name_step(b, PH_AFIXED);
                PH_AFIXED: begin
                    if (skip_cnt != 16'd0) begin
                        skip_cnt--;
                    end else begin
                        if (fix_idx >= AF_TTL_FIRST && fix_idx <= AF_TTL_LAST) begin
                            ttl_acc = {ttl_acc[23:0], b};
                        end else if (fix_idx == AF_RDLEN_HI) begin
                            rd_left = {b, 8'h00};
                        end else if (fix_idx == AF_RDLEN_LO) begin
                            rd_left[7:0] = b;
                        end
                        if (fix_idx == AFIXED_LAST) begin
                            // A TTL with the top bit set counts as zero.
                            ttl = ttl_acc[31] ? 32'd0 : ttl_acc;
                            if (!seen_answer || ttl < best) begin
                                best = ttl;
                            end
                            seen_answer = 1'b1;
                            if (rd_left == 16'd0) begin
                                answer_done();
                            end else begin
                                phase = PH_RDATA;
                            end
                        end
                        fix_idx++;
                    end
                end
                PH_RDATA: begin
                    rd_left--;
                    if (rd_left == 16'd0) begin
                        answer_done();
                    end
                end
                default: ;
            endcase
        end
        if (is_last) begin
            if (!bad && phase == PH_DONE && seen_answer) begin
                ttl_due.push_back(best[TTL_W-1:0]);
            end else begin
                ttl_due.push_back('0);
            end
            clear_scan();
        end
    endtask

    // Message construction.
    task automatic put_name();
        int n_labels;
        int len;
        if (name_no == poison_name) begin
            msg.push_back({poison_top ? 2'b10 : 2'b01, 6'($urandom)});
            poison_top = !poison_top;
        end
        n_labels = $urandom_range(0, 2);
        for (int i = 0; i < n_labels; i++) begin
            len = ($urandom_range(0, 19) == 0) ? 63 : $urandom_range(1, 6);
            msg.push_back(8'(len));
            repeat (len) msg.push_back(8'($urandom));
        end
        if ($urandom_range(0, 2) == 0) begin
            msg.push_back({LABEL_POINTER, 6'($urandom)});
            msg.push_back(8'($urandom));
        end else begin
            msg.push_back(8'h00);
        end
        name_no++;
    endtask

    task automatic put_header(input logic [15:0] qd, input logic [15:0] an);
        repeat (4) msg.push_back(8'($urandom));
        msg.push_back(qd[15:8]);
        msg.push_back(qd[7:0]);
        msg.push_back(an[15:8]);
        msg.push_back(an[7:0]);
        repeat (4) msg.push_back(8'($urandom));
    endtask

    task automatic put_questions(input int n);
        repeat (n) begin
            put_name();
            repeat (4) msg.push_back(8'($urandom));
        end
    endtask

    task automatic put_answers(input int n);
        logic [31:0] ttl;
        logic [15:0] rdlen;
        repeat (n) begin
            put_name();
            repeat (4) msg.push_back(8'($urandom));
            if (ttl_plan.size() != 0) begin
                ttl = ttl_plan.pop_front();
            end else begin
                case ($urandom_range(0, 9))
                    0: ttl = 32'd0;
                    1: ttl = 32'h7FFF_FFFF;
                    2: ttl = 32'h8000_0000 | $urandom;
                    3, 4, 5: ttl = $urandom_range(0, 1000);
                    default: ttl = $urandom;
                endcase
            end
            for (int i = 3; i >= 0; i--) msg.push_back(ttl[8*i +: 8]);
            rdlen = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(256, 300))
                                                 : 16'($urandom_range(0, 6));
            msg.push_back(rdlen[15:8]);
            msg.push_back(rdlen[7:0]);
            repeat (rdlen) msg.push_back(8'($urandom));
        end
    endtask

    task automatic chop(input int keep);
        while (msg.size() > keep) void'(msg.pop_back());
    endtask

    task automatic ship(input bit hold);
        scan_word_t w;
        foreach (msg[i]) begin
            w.data = msg[i];
            w.last = (i == msg.size() - 1);
            w.hold = hold && (i == 0);
            word_queue.push_back(w);
        end
        msg.delete();
        msgs_built++;
    endtask

    // Byte driver.
    always @(posedge aclk) begin : drive_proc
        scan_word_t w;
        logic take;
        bit calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_scan();
        end else begin
            take = s_valid && s_ready;
            if (take) begin
                scan_byte(s_data_byte, s_last_byte);
                bytes_sent++;
            end
            calm = (bytes_sent >= 900 && bytes_sent < 1300);
            if (s_valid && !take) begin
                // Word still pending: hold it unchanged.
            end else if (word_queue.size() != 0
                         && !(word_queue[0].hold && ttl_due.size() != 0)
                         && (calm || $urandom_range(0, 99) >= 11)) begin
                w = word_queue.pop_front();
                s_data_byte <= w.data;
                s_last_byte <= w.last;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor with its own long stall.
    always @(posedge aclk) begin : watch_proc
        logic [TTL_W-1:0] want;
        int stall_left;
        bit stall_done;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            stall_done = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (ttl_due.size() == 0) begin
                    $error("unexpected result: min_ttl = %0d", m_min_ttl);
                    errors++;
                end else begin
                    want = ttl_due.pop_front();
                    if (m_min_ttl !== want) begin
                        $error("min_ttl mismatch: expected %0d, got %0d", want, m_min_ttl);
                        errors++;
                    end
                end
                results_seen++;
            end
            if (results_seen >= 10 && !stall_done) begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (results_seen >= 20 && results_seen < 30)
                           || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    initial begin : stimulus
        int msgs_random;
        int qd;
        int an;
        int kind;

        // One-byte and eleven-byte messages both end inside the header.
        msg.push_back(8'hA5);
        ship(1'b0);
        put_header(16'd1, 16'd1);
        chop(11);
        ship(1'b0);
        // Header only, no answers.
        put_header(16'd0, 16'd0);
        ship(1'b0);
        // A TTL with the top bit set wins as zero.
        ttl_plan = '{32'hFFFF_FFFF, 32'd5};
        put_header(16'd0, 16'd2);
        put_answers(2);
        ship(1'b0);
        // Largest TTL that can be reported.
        ttl_plan = '{32'h7FFF_FFFF};
        put_header(16'd1, 16'd1);
        put_questions(1);
        put_answers(1);
        ship(1'b0);
        // Several questions and answers with trailing bytes after the last answer.
        ttl_plan = '{32'd900, 32'd300, 32'd600};
        put_header(16'd2, 16'd3);
        put_questions(2);
        put_answers(3);
        repeat (5) msg.push_back(8'($urandom));
        ship(1'b0);
        // Reserved label types, once in a question and once in an answer.
        poison_name = name_no;
        put_header(16'd1, 16'd1);
        put_questions(1);
        put_answers(1);
        ship(1'b0);
        poison_name = name_no + 1;
        put_header(16'd1, 16'd1);
        put_questions(1);
        put_answers(1);
        ship(1'b0);
        poison_name = -1;
        // Answer cut short by one byte.
        put_header(16'd0, 16'd1);
        put_answers(1);
        chop(msg.size() - 1);
        ship(1'b0);
        // Maximal counts with nothing behind them.
        put_header(16'hFFFF, 16'hFFFF);
        ship(1'b0);

        msgs_random = 0;
        while (word_queue.size() < 1650 || msgs_random < 36) begin
            kind = $urandom_range(0, 99);
            qd = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 1);
            an = $urandom_range(0, 3);
            if (kind < 94) begin
                if (kind >= 80 && kind < 88) begin
                    if (an == 0) an = 1;
                    poison_name = name_no + $urandom_range(0, qd + an - 1);
                end
                put_header(16'(qd), 16'(an));
                put_questions(qd);
                put_answers(an);
                poison_name = -1;
                if (kind < 70) begin
                    msgs_clean++;
                    if ($urandom_range(0, 4) == 0) begin
                        repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
                    end
                end else if (kind < 80) begin
                    chop($urandom_range(1, msg.size() - 1));
                end
            end else if (kind < 97) begin
                repeat ($urandom_range(1, 40)) msg.push_back(8'($urandom));
            end else begin
                put_header(16'($urandom), 16'($urandom));
                chop($urandom_range(1, 11));
            end
            msgs_random++;
            ship(msgs_random % 15 == 0);
        end

        while (!aresetn) @(posedge aclk);
        while (word_queue.size() != 0 || s_valid) @(posedge aclk);
        while (ttl_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Streamed %0d bytes in %0d messages (%0d well-formed random ones).",
                 bytes_sent, msgs_built, msgs_clean);
        $display("Checked %0d minimum-TTL results, %0d mismatches, %0d still owed.",
                 results_seen, errors, ttl_due.size());
        if (errors == 0 && ttl_due.size() == 0) begin
            $display("PASS dns_answer_min_ttl_scanner_unit");
        end else begin
            $display("FAIL dns_answer_min_ttl_scanner_unit");
        end
        $finish;
    end

endmodule
